// ===== hdl/nsfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsfc_pkg
// shared constants, codes and helpers of the nmea sentence framer checker
// ----------------------------------------------------------------------------
package nsfc_pkg;

  // longest line buffer, one slot is kept free as in the framing rule
  localparam int LINE_BYTES = 256;
  localparam int FILL_W     = $clog2(LINE_BYTES);

  localparam int BYTE_W   = 8;
  localparam int VERD_W   = 2;
  localparam int LEN_W    = 8;
  localparam int SUM_W    = 8;
  localparam int TOTAL_W  = 32;
  localparam int OUT_W    = VERD_W + LEN_W + SUM_W + TOTAL_W + 1;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

  // verdict codes
  localparam logic [VERD_W-1:0] VERD_VALID     = 2'd0;
  localparam logic [VERD_W-1:0] VERD_BAD_COUNT = 2'd1;
  localparam logic [VERD_W-1:0] VERD_BAD_EARLY = 2'd2;
  localparam logic [VERD_W-1:0] VERD_NO_DOLLAR = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // decode one ascii hex digit, either case
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t r;
    r.ok    = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h57);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nmea_sentence_framer_checker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_unit
// frames a received nmea 0183 byte stream into lines and checks checksums
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one received byte per item. a dollar sign restarts the
//   line, cr or lf ends it, other bytes are stored until the line is full.
//   each ended non-empty line gives one item on m_axis with its verdict,
//   length, computed xor, the running count of counted bad lines and the
//   locked flag. bytes that do not end a line give no output item.
// throughput and path
//   one byte per cycle while the result register is free or drains. an
//   accepted byte sits in the input register, is framed and checked, and
//   its result is captured in the result register that drives
//   m_axis_tvalid_o. the per-byte line state update is the only loop; it is
//   combinational and closes through the line state registers.
// reset
//   line state, locked flag and bad-line count clear; both channels idle.
// stall
//   a held result blocks the input register; while m_axis_tready_i is low
//   at most one more byte is taken, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [nsfc_pkg::BYTE_W-1:0]        s_axis_tdata_i,   // [7:0] rx_byte
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // [1:0] verdict, [9:2] line_len, [17:10] computed_sum,
  // [49:18] bad_total, [50] locked, [55:51] zero
  output logic [nsfc_pkg::OUT_BYTES_W-1:0]   m_axis_tdata_o
);

  localparam int FW = nsfc_pkg::FILL_W;

  // input register
  logic                        in_vld_q;
  logic [nsfc_pkg::BYTE_W-1:0] in_byte_q;
  logic                        advance;

  // line state
  logic [FW-1:0]               fill_q, fill_d;
  logic [nsfc_pkg::SUM_W-1:0]  xor_q, xor_d;
  logic [nsfc_pkg::BYTE_W-1:0] tail0_q, tail0_d, tail1_q, tail1_d, tail2_q, tail2_d;
  logic                        dollar_q, dollar_d;
  logic                        locked_q, locked_d;
  logic [nsfc_pkg::TOTAL_W-1:0] bad_q, bad_d;

  // result register
  logic                          out_vld_q;
  logic                          emit;
  logic [nsfc_pkg::VERD_W-1:0]   verd_d, verd_q;
  logic [nsfc_pkg::LEN_W-1:0]    len_d, len_q;
  logic [nsfc_pkg::SUM_W-1:0]    sum_d, sum_q;

  // per-byte decode
  logic                        is_eol, is_dollar, long_enough, ok;
  logic [FW-1:0]               base_fill;
  logic [nsfc_pkg::SUM_W-1:0]  base_xor, tail_sum;
  logic [nsfc_pkg::BYTE_W-1:0] base_t1, base_t2;
  logic                        base_dollar;
  nsfc_pkg::hex_digit_t        hex_hi, hex_lo;

  // the input register moves on when the result register is free or drains
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    is_eol    = (in_byte_q == nsfc_pkg::CH_LF) || (in_byte_q == nsfc_pkg::CH_CR);
    is_dollar = (in_byte_q == nsfc_pkg::CH_DOLLAR);

    // checksum check on the stored line, used only at end of line
    long_enough = (fill_q >= FW'(4));
    hex_hi      = nsfc_pkg::hex_decode(tail1_q);
    hex_lo      = nsfc_pkg::hex_decode(tail2_q);
    tail_sum    = xor_q ^ tail0_q ^ tail1_q ^ tail2_q;
    ok          = long_enough && dollar_q && (tail0_q == nsfc_pkg::CH_STAR) &&
                  hex_hi.ok && hex_lo.ok && ({hex_hi.value, hex_lo.value} == tail_sum);

    // a dollar sign starts from a cleared line
    base_fill   = is_dollar ? '0 : fill_q;
    base_xor    = is_dollar ? '0 : xor_q;
    base_t1     = is_dollar ? '0 : tail1_q;
    base_t2     = is_dollar ? '0 : tail2_q;
    base_dollar = is_dollar ? 1'b0 : dollar_q;

    fill_d   = fill_q;
    xor_d    = xor_q;
    tail0_d  = tail0_q;
    tail1_d  = tail1_q;
    tail2_d  = tail2_q;
    dollar_d = dollar_q;
    locked_d = locked_q;
    bad_d    = bad_q;
    emit     = 1'b0;
    verd_d   = nsfc_pkg::VERD_NO_DOLLAR;
    len_d    = nsfc_pkg::LEN_W'(fill_q);
    sum_d    = long_enough ? tail_sum : '0;

    if (is_eol) begin
      if (fill_q != '0) begin
        emit = 1'b1;
        priority if (ok) begin
          locked_d = 1'b1;
          verd_d   = nsfc_pkg::VERD_VALID;
        end else if (dollar_q && locked_q) begin
          bad_d  = bad_q + 1'b1;
          verd_d = nsfc_pkg::VERD_BAD_COUNT;
        end else if (dollar_q) begin
          verd_d = nsfc_pkg::VERD_BAD_EARLY;
        end else begin
          verd_d = nsfc_pkg::VERD_NO_DOLLAR;
        end
        fill_d   = '0;
        xor_d    = '0;
        tail0_d  = '0;
        tail1_d  = '0;
        tail2_d  = '0;
        dollar_d = 1'b0;
      end
    end else if (base_fill < FW'(nsfc_pkg::LINE_BYTES - 1)) begin
      if (base_fill == '0) begin
        dollar_d = is_dollar;
        xor_d    = base_xor;
      end else begin
        dollar_d = base_dollar;
        xor_d    = base_xor ^ in_byte_q;
      end
      tail0_d = base_t1;
      tail1_d = base_t2;
      tail2_d = in_byte_q;
      fill_d  = base_fill + 1'b1;
    end else begin
      // line full: drop the byte and start over
      fill_d   = '0;
      xor_d    = '0;
      tail0_d  = '0;
      tail1_d  = '0;
      tail2_d  = '0;
      dollar_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      xor_q     <= '0;
      tail0_q   <= '0;
      tail1_q   <= '0;
      tail2_q   <= '0;
      dollar_q  <= 1'b0;
      locked_q  <= 1'b0;
      bad_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        fill_q   <= fill_d;
        xor_q    <= xor_d;
        tail0_q  <= tail0_d;
        tail1_q  <= tail1_d;
        tail2_q  <= tail2_d;
        dollar_q <= dollar_d;
        locked_q <= locked_d;
        bad_q    <= bad_d;
      end
      if (advance) begin
        out_vld_q <= emit;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, bad count and locked flag read straight from state
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      verd_q <= verd_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(nsfc_pkg::OUT_BYTES_W - nsfc_pkg::OUT_W)'(0),
                            locked_q, bad_q, sum_q, len_q, verd_q};

endmodule
`default_nettype wire

// ===== hdl/nsfc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsfc_checker
// port-level checks of the nmea sentence framer checker
// ----------------------------------------------------------------------------
module nsfc_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid_i,
  input wire                              m_axis_tready_i,
  input wire [nsfc_pkg::OUT_BYTES_W-1:0]  m_axis_tdata_i
);

  logic [nsfc_pkg::VERD_W-1:0] verd;
  logic [nsfc_pkg::LEN_W-1:0]  len;
  logic                        locked;

  assign verd   = m_axis_tdata_i[1:0];
  assign len    = m_axis_tdata_i[9:2];
  assign locked = m_axis_tdata_i[50];

  // stalled item holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("output item changed while stalled");

  // a valid or counted line implies lock
  a_lock_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (verd == nsfc_pkg::VERD_VALID || verd == nsfc_pkg::VERD_BAD_COUNT)
      |-> locked)
    else $error("locked flag missing");

  // early bad lines only before lock
  a_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && verd == nsfc_pkg::VERD_BAD_EARLY |-> !locked)
    else $error("bad-before-lock verdict while locked");

  // ended lines are never empty
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> len != '0)
    else $error("empty line reported");

endmodule

bind nmea_sentence_framer_checker_unit nsfc_checker u_nsfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
`default_nettype wire
